[hw/rtl/mqbf_pkg.sv]
// ----------------------------------------------------------------------------
// Multi-queue byte FIFO manager package
// Shared widths, request and status codes, fill codes and the command and
// status structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package mqbf_pkg;

   localparam int QUEUES         = 8;
   localparam int POOL_BYTES     = 4096;
   localparam int MAX_READ_BURST = 64;

   localparam int SLOT_W = $clog2(QUEUES);
   localparam int ADDR_W = $clog2(POOL_BYTES);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int LEN_W  = 13;
   localparam int GNT_W  = 7;

   typedef enum logic [2:0] {
      REQ_ALLOC = 3'd0,
      REQ_WRITE = 3'd1,
      REQ_READ  = 3'd2,
      REQ_QUERY = 3'd3,
      REQ_CLEAR = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_QUEUE  = 3'd1,
      ST_NO_ROOM   = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_TABLE_FULL = 3'd4,
      ST_ZERO_LEN  = 3'd5
   } status_code_type;

   localparam logic [1:0] FILL_EMPTY = 2'd0;
   localparam logic [1:0] FILL_USING = 2'd1;
   localparam logic [1:0] FILL_FULL  = 2'd2;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_DECIDE,
      CTL_READ_FETCH,
      CTL_READ_EMIT,
      CTL_RESPOND
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;      // latch the incoming word
      logic execute;      // apply the single-result operation
      logic read_start;   // set up a read burst
      logic read_fetch;   // issue a pool read at the read pointer
      logic read_advance; // step the read pointer
      logic read_finish;  // update the fill status after the burst
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_read_burst; // decided request is a read that grants bytes
      logic read_done;     // current byte is the final one
   } stat_type;

endpackage

[hw/rtl/mqbf_datapath.sv]
// ----------------------------------------------------------------------------
// Multi-queue byte FIFO manager datapath
// Holds the slot table, the shared byte pool, the burst tracker and the
// result register, and carries out the commands of the controller.
// ----------------------------------------------------------------------------
module mqbf_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  mqbf_pkg::cmd_type              cmd,
   output mqbf_pkg::stat_type             stat,
   input  logic [2:0]                     req_type,
   input  logic [7:0]                     req_queue_id,
   input  logic [mqbf_pkg::LEN_W-1:0]     req_length,
   input  logic [7:0]                     req_in_byte,
   input  logic                           req_burst_first,
   output logic [2:0]                     rsp_status,
   output logic [7:0]                     rsp_out_byte,
   output logic [mqbf_pkg::GNT_W-1:0]     rsp_granted,
   output logic [mqbf_pkg::LEN_W-1:0]     rsp_readable,
   output logic [mqbf_pkg::LEN_W-1:0]     rsp_writable,
   output logic                           rsp_last
);

   localparam int SW = mqbf_pkg::SLOT_W;
   localparam int AW = mqbf_pkg::ADDR_W;
   localparam int CW = mqbf_pkg::CNT_W;
   localparam int LW = mqbf_pkg::LEN_W;
   localparam int GW = mqbf_pkg::GNT_W;
   localparam int NQ = mqbf_pkg::QUEUES;

   // Slot table.
   logic [7:0]    slot_id_ff   [NQ];
   logic [NQ-1:0] slot_valid_ff;
   logic [AW-1:0] slot_base_ff [NQ];
   logic [CW-1:0] slot_cap_ff  [NQ];
   logic [AW-1:0] slot_rd_ff   [NQ];
   logic [AW-1:0] slot_wr_ff   [NQ];
   logic [1:0]    slot_fill_ff [NQ];

   logic [CW-1:0] pool_free_ff;
   logic [SW-1:0] burst_slot_ff;
   logic [LW-1:0] burst_left_ff;
   logic          burst_refused_ff;

   logic [7:0] pool_mem [mqbf_pkg::POOL_BYTES];

   // Captured request.
   logic [2:0]    q_type_ff;
   logic [7:0]    q_id_ff;
   logic [LW-1:0] q_len_ff;
   logic [7:0]    q_byte_ff;
   logic          q_first_ff;

   // Decoded lookup of the captured word.
   logic [SW-1:0] hit_slot_ff;
   logic          hit_ff;
   logic [SW-1:0] free_slot_ff;
   logic          has_free_ff;
   logic [CW-1:0] hit_readable_ff;
   logic [CW-1:0] hit_writable_ff;

   // Read burst tracking.
   logic [GW-1:0] rd_grant_ff;
   logic [GW-1:0] rd_count_ff;

   // Result register.
   logic [2:0]    o_status_ff;
   logic [7:0]    o_byte_ff;
   logic [GW-1:0] o_granted_ff;
   logic [LW-1:0] o_readable_ff;
   logic [LW-1:0] o_writable_ff;
   logic          o_last_ff;

   // Lookup of the incoming ID and the first free slot.
   logic [SW-1:0] hit_slot_in;
   logic          hit_in;
   logic [SW-1:0] free_slot_in;
   logic          has_free_in;
   always_comb begin
      hit_slot_in  = '0;
      hit_in       = 1'b0;
      free_slot_in = '0;
      has_free_in  = 1'b0;
      for (int i = NQ - 1; i >= 0; i--) begin
         if (slot_valid_ff[i] && slot_id_ff[i] == req_queue_id) begin
            hit_slot_in = SW'(i);
            hit_in      = 1'b1;
         end
         if (!slot_valid_ff[i]) begin
            free_slot_in = SW'(i);
            has_free_in  = 1'b1;
         end
      end
   end

   // Readable and writable counts of the hit slot.
   logic [CW-1:0] rd_cnt_in;
   logic [CW-1:0] wr_cnt_in;
   always_comb begin
      logic [CW-1:0] rd;
      logic [CW-1:0] wr;
      logic [CW-1:0] cap;
      rd  = {1'b0, slot_rd_ff[hit_slot_in]};
      wr  = {1'b0, slot_wr_ff[hit_slot_in]};
      cap = slot_cap_ff[hit_slot_in];
      priority case (slot_fill_ff[hit_slot_in])
         mqbf_pkg::FILL_USING: begin
            rd_cnt_in = (rd > wr) ? cap - rd + wr : wr - rd;
            wr_cnt_in = (rd > wr) ? rd - wr : cap + rd - wr;
         end
         mqbf_pkg::FILL_FULL: begin
            rd_cnt_in = cap;
            wr_cnt_in = '0;
         end
         default: begin
            rd_cnt_in = '0;
            wr_cnt_in = cap;
         end
      endcase
   end

   // Capture of the request and its lookup.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         q_type_ff       <= req_type;
         q_id_ff         <= req_queue_id;
         q_len_ff        <= req_length;
         q_byte_ff       <= req_in_byte;
         q_first_ff      <= req_burst_first;
         hit_slot_ff     <= hit_slot_in;
         hit_ff          <= hit_in;
         free_slot_ff    <= free_slot_in;
         has_free_ff     <= has_free_in;
         hit_readable_ff <= rd_cnt_in;
         hit_writable_ff <= wr_cnt_in;
      end
   end

   // Grant of the read: min(requested, readable, burst limit).
   logic [CW-1:0] lim_in;
   logic [GW-1:0] grant_in;
   always_comb begin
      lim_in = (CW'(q_len_ff) < hit_readable_ff) ? CW'(q_len_ff) : hit_readable_ff;
      grant_in = (lim_in > CW'(mqbf_pkg::MAX_READ_BURST))
                 ? GW'(mqbf_pkg::MAX_READ_BURST) : GW'(lim_in);
   end

   assign stat.is_read_burst = (q_type_ff == mqbf_pkg::REQ_READ) && hit_ff
                               && (q_len_ff != '0) && (grant_in != '0);
   assign stat.read_done     = (rd_count_ff == rd_grant_ff);

   // Write burst decision.
   logic          wr_start_bad;
   logic [2:0]    wr_start_status;
   logic          wr_store;
   always_comb begin
      wr_start_bad    = 1'b0;
      wr_start_status = mqbf_pkg::ST_OK;
      if (!hit_ff) begin
         wr_start_bad = 1'b1; wr_start_status = mqbf_pkg::ST_NO_QUEUE;
      end else if (q_len_ff == '0) begin
         wr_start_bad = 1'b1; wr_start_status = mqbf_pkg::ST_ZERO_LEN;
      end else if (CW'(q_len_ff) > hit_writable_ff) begin
         wr_start_bad = 1'b1; wr_start_status = mqbf_pkg::ST_NO_ROOM;
      end
      if (q_first_ff)
         wr_store = !wr_start_bad;
      else
         wr_store = !burst_refused_ff && (burst_left_ff != '0)
                    && slot_valid_ff[burst_slot_ff];
   end

   logic [SW-1:0] wslot;
   logic [AW-1:0] wr_next;
   logic [SW-1:0] rslot;
   logic [AW-1:0] rd_next;
   assign wslot = q_first_ff ? hit_slot_ff : burst_slot_ff;
   assign wr_next = (CW'(slot_wr_ff[wslot]) + CW'(1) >= slot_cap_ff[wslot])
                    ? '0 : slot_wr_ff[wslot] + AW'(1);
   assign rslot = hit_slot_ff;
   assign rd_next = (CW'(slot_rd_ff[rslot]) + CW'(1) >= slot_cap_ff[rslot])
                    ? '0 : slot_rd_ff[rslot] + AW'(1);

   // Pool memory: one write port, one registered read port.
   logic [AW-1:0] rd_addr;
   assign rd_addr = slot_base_ff[rslot] + slot_rd_ff[rslot];
   always_ff @(posedge clock) begin
      if (cmd.execute && q_type_ff == mqbf_pkg::REQ_WRITE && wr_store)
         pool_mem[slot_base_ff[wslot] + slot_wr_ff[wslot]] <= q_byte_ff;
      if (cmd.read_fetch)
         o_byte_ff <= pool_mem[rd_addr];
   end

   // Slot table, pool and burst state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff    <= '0;
         pool_free_ff     <= CW'(mqbf_pkg::POOL_BYTES);
         burst_slot_ff    <= '0;
         burst_left_ff    <= '0;
         burst_refused_ff <= 1'b0;
         for (int i = 0; i < NQ; i++) begin
            slot_id_ff[i]   <= '0;
            slot_base_ff[i] <= '0;
            slot_cap_ff[i]  <= '0;
            slot_rd_ff[i]   <= '0;
            slot_wr_ff[i]   <= '0;
            slot_fill_ff[i] <= mqbf_pkg::FILL_EMPTY;
         end
      end else begin
         if (cmd.execute) begin
            unique case (q_type_ff)
               mqbf_pkg::REQ_ALLOC: begin
                  if (q_len_ff != '0 && CW'(q_len_ff) <= pool_free_ff && !hit_ff
                      && has_free_ff) begin
                     slot_valid_ff[free_slot_ff] <= 1'b1;
                     slot_id_ff[free_slot_ff]    <= q_id_ff;
                     slot_base_ff[free_slot_ff]  <=
                        AW'(CW'(mqbf_pkg::POOL_BYTES) - pool_free_ff);
                     slot_cap_ff[free_slot_ff]   <= CW'(q_len_ff);
                     slot_rd_ff[free_slot_ff]    <= '0;
                     slot_wr_ff[free_slot_ff]    <= '0;
                     slot_fill_ff[free_slot_ff]  <= mqbf_pkg::FILL_EMPTY;
                     pool_free_ff <= pool_free_ff - CW'(q_len_ff);
                  end
               end
               mqbf_pkg::REQ_WRITE: begin
                  if (q_first_ff) begin
                     burst_refused_ff <= wr_start_bad;
                     burst_left_ff    <= wr_start_bad ? '0 : q_len_ff - LW'(1);
                     if (!wr_start_bad)
                        burst_slot_ff <= hit_slot_ff;
                  end else if (wr_store) begin
                     burst_left_ff <= burst_left_ff - LW'(1);
                  end
                  if (wr_store) begin
                     slot_wr_ff[wslot]   <= wr_next;
                     slot_fill_ff[wslot] <= (wr_next == slot_rd_ff[wslot])
                                            ? mqbf_pkg::FILL_FULL : mqbf_pkg::FILL_USING;
                  end
               end
               mqbf_pkg::REQ_CLEAR: begin
                  if (hit_ff) begin
                     slot_rd_ff[hit_slot_ff]   <= slot_wr_ff[hit_slot_ff];
                     slot_fill_ff[hit_slot_ff] <= mqbf_pkg::FILL_EMPTY;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.read_advance)
            slot_rd_ff[rslot] <= rd_next;
         if (cmd.read_finish)
            slot_fill_ff[rslot] <= (slot_rd_ff[rslot] == slot_wr_ff[rslot])
                                   ? mqbf_pkg::FILL_EMPTY : mqbf_pkg::FILL_USING;
      end
   end

   // Read burst counters.
   always_ff @(posedge clock) begin
      if (cmd.read_start) begin
         rd_grant_ff <= grant_in;
         rd_count_ff <= '0;
      end else if (cmd.read_advance) begin
         rd_count_ff <= rd_count_ff + GW'(1);
      end
   end

   // Single-result fields.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         o_granted_ff  <= '0;
         o_readable_ff <= '0;
         o_writable_ff <= '0;
         o_last_ff     <= 1'b1;
         o_status_ff   <= mqbf_pkg::ST_OK;
         priority case (q_type_ff)
            mqbf_pkg::REQ_ALLOC: begin
               if (q_len_ff == '0)                    o_status_ff <= mqbf_pkg::ST_ZERO_LEN;
               else if (CW'(q_len_ff) > pool_free_ff) o_status_ff <= mqbf_pkg::ST_NO_ROOM;
               else if (hit_ff)                        o_status_ff <= mqbf_pkg::ST_DUPLICATE;
               else if (!has_free_ff)                  o_status_ff <= mqbf_pkg::ST_TABLE_FULL;
            end
            mqbf_pkg::REQ_WRITE: begin
               if (q_first_ff && wr_start_bad) o_status_ff <= wr_start_status;
               else if (!wr_store)             o_status_ff <= mqbf_pkg::ST_NO_ROOM;
            end
            mqbf_pkg::REQ_READ: begin
               if (!hit_ff)               o_status_ff <= mqbf_pkg::ST_NO_QUEUE;
               else if (q_len_ff == '0)   o_status_ff <= mqbf_pkg::ST_ZERO_LEN;
            end
            mqbf_pkg::REQ_QUERY: begin
               if (!hit_ff) begin
                  o_status_ff <= mqbf_pkg::ST_NO_QUEUE;
               end else begin
                  o_readable_ff <= LW'(hit_readable_ff);
                  o_writable_ff <= LW'(hit_writable_ff);
               end
            end
            mqbf_pkg::REQ_CLEAR: begin
               if (!hit_ff) o_status_ff <= mqbf_pkg::ST_NO_QUEUE;
            end
            default: ;
         endcase
      end else if (cmd.read_fetch) begin
         // The count has not yet moved on, so this byte is the last one when
         // one more step reaches the grant.
         o_status_ff   <= mqbf_pkg::ST_OK;
         o_granted_ff  <= rd_grant_ff;
         o_readable_ff <= '0;
         o_writable_ff <= '0;
         o_last_ff     <= (rd_count_ff + GW'(1) == rd_grant_ff);
      end
   end

   // The byte field is zero outside read bursts.
   logic byte_live_ff;
   always_ff @(posedge clock) begin
      if (reset)               byte_live_ff <= 1'b0;
      else if (cmd.execute)    byte_live_ff <= 1'b0;
      else if (cmd.read_fetch) byte_live_ff <= 1'b1;
   end

   assign rsp_status   = o_status_ff;
   assign rsp_out_byte = byte_live_ff ? o_byte_ff : 8'd0;
   assign rsp_granted  = o_granted_ff;
   assign rsp_readable = o_readable_ff;
   assign rsp_writable = o_writable_ff;
   assign rsp_last     = o_last_ff;

endmodule

[hw/rtl/mqbf_ctrl.sv]
// ----------------------------------------------------------------------------
// Multi-queue byte FIFO manager controller
// Sequences capture, decision, read bursts and the result handshake.
// ----------------------------------------------------------------------------
module mqbf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mqbf_pkg::cmd_type    cmd,
   input  mqbf_pkg::stat_type   stat
);

   mqbf_pkg::ctl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= mqbf_pkg::CTL_IDLE;
      else       state_ff <= state_in;
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         mqbf_pkg::CTL_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = mqbf_pkg::CTL_DECIDE;
            end
         end
         mqbf_pkg::CTL_DECIDE: begin
            if (stat.is_read_burst) begin
               cmd.read_start = 1'b1;
               state_in       = mqbf_pkg::CTL_READ_FETCH;
            end else begin
               cmd.execute = 1'b1;
               state_in    = mqbf_pkg::CTL_RESPOND;
            end
         end
         mqbf_pkg::CTL_READ_FETCH: begin
            cmd.read_fetch   = 1'b1;
            cmd.read_advance = 1'b1;
            state_in         = mqbf_pkg::CTL_READ_EMIT;
         end
         mqbf_pkg::CTL_READ_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               // After the advance the count has moved on, so the last byte is
               // the one at which the count equals the grant.
               if (stat.read_done) begin
                  cmd.read_finish = 1'b1;
                  state_in        = mqbf_pkg::CTL_IDLE;
               end else begin
                  state_in = mqbf_pkg::CTL_READ_FETCH;
               end
            end
         end
         mqbf_pkg::CTL_RESPOND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = mqbf_pkg::CTL_IDLE;
         end
         default: state_in = mqbf_pkg::CTL_IDLE;
      endcase
   end

endmodule

[hw/rtl/multi_queue_byte_fifo_manager_core.sv]
// ----------------------------------------------------------------------------
// Multi-queue byte FIFO manager
// Several byte ring buffers carved from one shared pool, with allocate,
// burst write, read, query and clear requests.
// ----------------------------------------------------------------------------
// Flow: a request is captured, then decided; a single-result request is
// executed and its result offered, a read emits its bytes one by one from
// the registered pool port. Requests wait until the last result is taken.
// Reset: synchronous, clears the slot table, the burst tracker and the
// controller; pool contents are undefined until written.
module multi_queue_byte_fifo_manager_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_type,
   input  logic [7:0]                     req_queue_id,
   input  logic [mqbf_pkg::LEN_W-1:0]     req_length,
   input  logic [7:0]                     req_in_byte,
   input  logic                           req_burst_first,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_status,
   output logic [7:0]                     rsp_out_byte,
   output logic [mqbf_pkg::GNT_W-1:0]     rsp_granted,
   output logic [mqbf_pkg::LEN_W-1:0]     rsp_readable,
   output logic [mqbf_pkg::LEN_W-1:0]     rsp_writable,
   output logic                           rsp_last
);

   mqbf_pkg::cmd_type  cmd;
   mqbf_pkg::stat_type stat;

   mqbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   mqbf_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_queue_id    (req_queue_id),
      .req_length      (req_length),
      .req_in_byte     (req_in_byte),
      .req_burst_first (req_burst_first),
      .rsp_status      (rsp_status),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_granted     (rsp_granted),
      .rsp_readable    (rsp_readable),
      .rsp_writable    (rsp_writable),
      .rsp_last        (rsp_last)
   );

endmodule

[hw/rtl/mqbf_checker.sv]
// ----------------------------------------------------------------------------
// Multi-queue byte FIFO manager checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module mqbf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [2:0]                 rsp_status,
   input logic [mqbf_pkg::GNT_W-1:0] rsp_granted,
   input logic                       rsp_last
);

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled result word changed");

   // No request is taken while a result is being offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a result is pending");

   // A grant never exceeds the burst limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_granted <= mqbf_pkg::GNT_W'(mqbf_pkg::MAX_READ_BURST))
      else $error("grant above burst limit");

   // A word carrying a grant reports success.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted != '0 |-> rsp_status == mqbf_pkg::ST_OK)
      else $error("granted read word with error status");

endmodule

bind multi_queue_byte_fifo_manager_core mqbf_checker u_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_status  (rsp_status),
   .rsp_granted (rsp_granted),
   .rsp_last    (rsp_last)
);

[tb/tb_multi_queue_byte_fifo_manager_core.sv]
// ----------------------------------------------------------------------------
// Multi-queue byte FIFO manager testbench
// Drives allocate, burst write, read, query and clear words into the core,
// predicts every result word from a behavioural copy of the slot table and
// pool, and compares each returned word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multi_queue_byte_fifo_manager_core;

   localparam int QUEUES         = mqbf_pkg::QUEUES;
   localparam int POOL_BYTES     = mqbf_pkg::POOL_BYTES;
   localparam int MAX_READ_BURST = mqbf_pkg::MAX_READ_BURST;
   localparam int LEN_W          = mqbf_pkg::LEN_W;
   localparam int GNT_W          = mqbf_pkg::GNT_W;

   // One result word as the core presents it.
   typedef struct {
      logic [2:0]       status;
      logic [7:0]       out_byte;
      logic [GNT_W-1:0] granted;
      logic [LEN_W-1:0] readable;
      logic [LEN_W-1:0] writable;
      logic             last;
   } rsp_word_type;

   // Buffer table predictor and store of expected result words.
   class fifo_table_scoreboard;
      logic [7:0] slot_tag   [QUEUES];
      bit         slot_used  [QUEUES];
      int         slot_start [QUEUES];
      int         slot_size  [QUEUES];
      int         slot_rd    [QUEUES];
      int         slot_wr    [QUEUES];
      logic [1:0] slot_state [QUEUES];
      logic [7:0] pool [POOL_BYTES];
      int         pool_left;
      int         open_slot;
      int         open_left;
      bit         open_refused;
      rsp_word_type awaited[$];
      int         errors;

      function new();
         for (int i = 0; i < QUEUES; i++) begin
            slot_tag[i] = 0; slot_used[i] = 0; slot_start[i] = 0; slot_size[i] = 0;
            slot_rd[i] = 0; slot_wr[i] = 0; slot_state[i] = mqbf_pkg::FILL_EMPTY;
         end
         pool_left = POOL_BYTES;
         open_slot = 0;
         open_left = 0;
         open_refused = 0;
         errors = 0;
      endfunction

      function int lookup(logic [7:0] id);
         for (int i = 0; i < QUEUES; i++)
            if (slot_used[i] && slot_tag[i] == id) return i;
         return -1;
      endfunction

      function int fill_count(int s);
         if (slot_state[s] == mqbf_pkg::FILL_USING)
            return slot_rd[s] > slot_wr[s] ? slot_size[s] - slot_rd[s] + slot_wr[s]
                                            : slot_wr[s] - slot_rd[s];
         if (slot_state[s] == mqbf_pkg::FILL_FULL) return slot_size[s];
         return 0;
      endfunction

      function int room_count(int s);
         return slot_size[s] - fill_count(s);
      endfunction

      function void push(logic [2:0] st, logic [7:0] b = 0, int g = 0, int r = 0,
                         int w = 0, bit last = 1);
         rsp_word_type x;
         x.status = st; x.out_byte = b; x.granted = GNT_W'(g);
         x.readable = LEN_W'(r); x.writable = LEN_W'(w); x.last = last;
         awaited.push_back(x);
      endfunction

      // Work out the result words caused by one accepted request word.
      function void note_request(logic [2:0] kind, logic [7:0] id, logic [LEN_W-1:0] len,
                                 logic [7:0] data, bit first);
         int s, n, fs;
         s = lookup(id);
         case (kind)
            mqbf_pkg::REQ_ALLOC: begin
               fs = -1;
               for (int i = QUEUES - 1; i >= 0; i--) if (!slot_used[i]) fs = i;
               if (len == 0) push(mqbf_pkg::ST_ZERO_LEN);
               else if (len > pool_left) push(mqbf_pkg::ST_NO_ROOM);
               else if (s >= 0) push(mqbf_pkg::ST_DUPLICATE);
               else if (fs < 0) push(mqbf_pkg::ST_TABLE_FULL);
               else begin
                  slot_used[fs] = 1; slot_tag[fs] = id;
                  slot_start[fs] = POOL_BYTES - pool_left; slot_size[fs] = len;
                  slot_rd[fs] = 0; slot_wr[fs] = 0; slot_state[fs] = mqbf_pkg::FILL_EMPTY;
                  pool_left -= len;
                  push(mqbf_pkg::ST_OK);
               end
            end
            mqbf_pkg::REQ_WRITE: begin
               if (first) begin
                  open_left = 0;
                  open_refused = 1;
                  if (s < 0) begin push(mqbf_pkg::ST_NO_QUEUE); return; end
                  if (len == 0) begin push(mqbf_pkg::ST_ZERO_LEN); return; end
                  if (len > room_count(s)) begin push(mqbf_pkg::ST_NO_ROOM); return; end
                  open_slot = s; open_left = len; open_refused = 0;
               end
               if (open_refused || open_left == 0 || !slot_used[open_slot]) begin
                  push(mqbf_pkg::ST_NO_ROOM);
                  return;
               end
               pool[(slot_start[open_slot] + slot_wr[open_slot]) % POOL_BYTES] = data;
               slot_wr[open_slot] = (slot_wr[open_slot] + 1 >= slot_size[open_slot]) ? 0
                                    : slot_wr[open_slot] + 1;
               slot_state[open_slot] = (slot_wr[open_slot] == slot_rd[open_slot])
                                       ? mqbf_pkg::FILL_FULL : mqbf_pkg::FILL_USING;
               open_left--;
               push(mqbf_pkg::ST_OK);
            end
            mqbf_pkg::REQ_READ: begin
               if (s < 0) begin push(mqbf_pkg::ST_NO_QUEUE); return; end
               if (len == 0) begin push(mqbf_pkg::ST_ZERO_LEN); return; end
               n = fill_count(s);
               if (n > len) n = len;
               if (n > MAX_READ_BURST) n = MAX_READ_BURST;
               if (n == 0) begin push(mqbf_pkg::ST_OK); return; end
               for (int i = 0; i < n; i++) begin
                  push(mqbf_pkg::ST_OK, pool[(slot_start[s] + slot_rd[s]) % POOL_BYTES],
                       n, 0, 0, i + 1 == n);
                  slot_rd[s] = (slot_rd[s] + 1 >= slot_size[s]) ? 0 : slot_rd[s] + 1;
               end
               slot_state[s] = (slot_rd[s] == slot_wr[s])
                               ? mqbf_pkg::FILL_EMPTY : mqbf_pkg::FILL_USING;
            end
            mqbf_pkg::REQ_QUERY: begin
               if (s < 0) push(mqbf_pkg::ST_NO_QUEUE);
               else push(mqbf_pkg::ST_OK, 0, 0, fill_count(s), room_count(s));
            end
            mqbf_pkg::REQ_CLEAR: begin
               if (s < 0) push(mqbf_pkg::ST_NO_QUEUE);
               else begin
                  slot_rd[s] = slot_wr[s];
                  slot_state[s] = mqbf_pkg::FILL_EMPTY;
                  push(mqbf_pkg::ST_OK);
               end
            end
            default: push(mqbf_pkg::ST_OK);
         endcase
      endfunction

      // Compare one returned word with the oldest expectation.
      function void check_result(rsp_word_type got);
         rsp_word_type x;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result word status=%0d byte=%0h", $time,
                     got.status, got.out_byte);
            errors++;
            return;
         end
         x = awaited.pop_front();
         if (got.status !== x.status)
            begin $display("%0t: status exp %0d got %0d", $time, x.status, got.status); errors++; end
         if (got.out_byte !== x.out_byte)
            begin $display("%0t: byte exp %0h got %0h", $time, x.out_byte, got.out_byte); errors++; end
         if (got.granted !== x.granted)
            begin $display("%0t: granted exp %0d got %0d", $time, x.granted, got.granted); errors++; end
         if (got.readable !== x.readable)
            begin $display("%0t: readable exp %0d got %0d", $time, x.readable, got.readable); errors++; end
         if (got.writable !== x.writable)
            begin $display("%0t: writable exp %0d got %0d", $time, x.writable, got.writable); errors++; end
         if (got.last !== x.last)
            begin $display("%0t: last exp %0b got %0b", $time, x.last, got.last); errors++; end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [2:0]       req_type;
   logic [7:0]       req_queue_id;
   logic [LEN_W-1:0] req_length;
   logic [7:0]       req_in_byte;
   logic             req_burst_first;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [2:0]       rsp_status;
   logic [7:0]       rsp_out_byte;
   logic [GNT_W-1:0] rsp_granted;
   logic [LEN_W-1:0] rsp_readable;
   logic [LEN_W-1:0] rsp_writable;
   logic             rsp_last;

   fifo_table_scoreboard board;
   logic [7:0] known_ids [QUEUES];
   int         words_seen;

   multi_queue_byte_fifo_manager_core uut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Offer one request word and hold it until the core takes it.
   task automatic send_word(logic [2:0] kind, logic [7:0] id, int len,
                            logic [7:0] data = 0, bit first = 0);
      int gap;
      req_valid       <= 1;
      req_type        <= kind;
      req_queue_id    <= id;
      req_length      <= LEN_W'(len);
      req_in_byte     <= data;
      req_burst_first <= first;
      do @(posedge clock); while (req_stall);
      board.note_request(kind, id, LEN_W'(len), data, first);
      gap = $urandom_range(0, 99);
      gap = gap < 60 ? 0 : gap < 92 ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Write a burst of random bytes to one buffer.
   task automatic send_burst(logic [7:0] id, int len, int count);
      for (int i = 0; i < count; i++)
         send_word(mqbf_pkg::REQ_WRITE, id, i == 0 ? len : $urandom_range(0, 4095),
                   8'($urandom_range(0, 255)), i == 0);
   endtask

   // Result side: check each accepted word, then choose the next stall level.
   initial begin : receiver
      int run_left, hold_left;
      bit run_stall, held;
      run_left = 0; hold_left = 0; run_stall = 0; held = 0; words_seen = 0;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            rsp_word_type got;
            got.status = rsp_status; got.out_byte = rsp_out_byte;
            got.granted = rsp_granted; got.readable = rsp_readable;
            got.writable = rsp_writable; got.last = rsp_last;
            board.check_result(got);
            words_seen++;
         end
         // One long hold-off so that the core backs up into its input.
         if (!held && words_seen >= 150) begin
            held = 1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1;
         end else begin
            if (run_left == 0) begin
               int pick;
               pick = $urandom_range(0, 99);
               if (pick < 65) begin run_stall = 0; run_left = $urandom_range(1, 20); end
               else if (pick < 94) begin run_stall = 1; run_left = $urandom_range(1, 3); end
               else begin run_stall = 1; run_left = $urandom_range(10, 40); end
            end
            run_left--;
            rsp_stall <= run_stall;
         end
      end
   end

   // Stimulus and end of run.
   initial begin : stimulus
      int caps [QUEUES];
      int q, len, cnt, nw, kind_pick, waited;
      board = new();
      known_ids = '{8'h10, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h7E, 8'h33, 8'hC5};
      caps = '{8, 1, 300, 64, 17, 100, 5, 0};
      reset = 1;
      req_valid = 0; req_type = mqbf_pkg::REQ_ALLOC; req_queue_id = 0; req_length = 0;
      req_in_byte = 0; req_burst_first = 0;
      repeat (2) @(posedge clock);
      reset <= 0;

      // Directed: error codes, a full buffer, reads past the limits.
      send_word(mqbf_pkg::REQ_ALLOC, 8'h10, 0);
      send_word(mqbf_pkg::REQ_ALLOC, 8'h10, 8);
      send_word(mqbf_pkg::REQ_ALLOC, 8'h10, 8);
      send_word(mqbf_pkg::REQ_ALLOC, 8'h55, 4096);
      send_word(mqbf_pkg::REQ_QUERY, 8'h55, 0);
      send_word(mqbf_pkg::REQ_QUERY, 8'h10, 0);
      send_word(mqbf_pkg::REQ_WRITE, 8'h55, 3, 8'hAA, 1);
      send_word(mqbf_pkg::REQ_WRITE, 8'h10, 0, 8'hAA, 1);
      send_word(mqbf_pkg::REQ_WRITE, 8'h10, 9, 8'hAA, 1);
      send_word(mqbf_pkg::REQ_WRITE, 8'h10, 2, 8'hAA, 0);
      send_word(mqbf_pkg::REQ_WRITE, 8'h10, 8, 8'h00, 1);
      for (int i = 0; i < 6; i++)
         send_word(mqbf_pkg::REQ_WRITE, 8'h10, 0, 8'(8'h11 * i), 0);
      send_word(mqbf_pkg::REQ_WRITE, 8'h10, 0, 8'hFF, 0);
      send_word(mqbf_pkg::REQ_WRITE, 8'h10, 0, 8'h5A, 0);
      send_word(mqbf_pkg::REQ_QUERY, 8'h10, 0);
      send_word(mqbf_pkg::REQ_READ, 8'h10, 0);
      send_word(mqbf_pkg::REQ_READ, 8'h55, 4);
      send_word(mqbf_pkg::REQ_READ, 8'h10, 3);
      send_word(mqbf_pkg::REQ_READ, 8'h10, 4096);
      send_word(mqbf_pkg::REQ_READ, 8'h10, 1);
      send_word(mqbf_pkg::REQ_WRITE, 8'h10, 4, 8'h77, 1);
      send_word(mqbf_pkg::REQ_WRITE, 8'h10, 2, 8'h66, 1);
      send_word(mqbf_pkg::REQ_CLEAR, 8'h10, 0);
      send_word(mqbf_pkg::REQ_CLEAR, 8'h55, 0);

      // Fill the table; the last buffer takes exactly what is left.
      for (int i = 1; i < QUEUES; i++)
         send_word(mqbf_pkg::REQ_ALLOC, known_ids[i],
                   i == QUEUES - 1 ? board.pool_left : caps[i]);
      send_word(mqbf_pkg::REQ_ALLOC, 8'h99, 1);

      // Random: mostly whole bursts and reads on known buffers, some noise.
      // Oversized bursts are refused, so only a few of their words are sent.
      cnt = 0;
      while (cnt < 480) begin
         q = $urandom_range(0, QUEUES - 1);
         kind_pick = $urandom_range(0, 99);
         if (kind_pick < 45) begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4096)
                                            : $urandom_range(1, 24);
            if (len > 24) nw = $urandom_range(1, 3);
            else if ($urandom_range(0, 5) == 0) nw = $urandom_range(1, len + 2);
            else nw = (len == 0) ? 1 : len;
            send_burst($urandom_range(0, 19) == 0 ? 8'($urandom) : known_ids[q], len, nw);
            cnt += nw;
         end else if (kind_pick < 75) begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(0, 4096)
                                            : $urandom_range(0, 70);
            send_word(mqbf_pkg::REQ_READ, known_ids[q], len);
            cnt++;
         end else if (kind_pick < 85) begin
            send_word(mqbf_pkg::REQ_QUERY,
                      $urandom_range(0, 9) == 0 ? 8'($urandom) : known_ids[q], 0);
            cnt++;
         end else if (kind_pick < 90) begin
            send_word(mqbf_pkg::REQ_CLEAR,
                      $urandom_range(0, 4) == 0 ? 8'($urandom) : known_ids[q], 0);
            cnt++;
         end else if (kind_pick < 95) begin
            send_word(mqbf_pkg::REQ_WRITE, known_ids[q], $urandom_range(0, 4096),
                      8'($urandom), 0);
            cnt++;
         end else begin
            send_word(mqbf_pkg::REQ_ALLOC, 8'($urandom), $urandom_range(0, 4096));
            cnt++;
         end
      end
      req_valid <= 0;

      // Drain, then let the pipeline settle.
      waited = 0;
      while (board.awaited.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.awaited.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Safety net against a hung handshake.
   initial begin : watchdog
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
